// ===== src/tdfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdfp_pkg
// Shared types and constants of the tagged decimal field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tdfp_pkg;

    localparam int INT_W      = 15;
    localparam int FRAC_ACC_W = 10;
    localparam int VALUE_W    = 24;
    localparam int POSE_W     = 28;

    localparam logic [INT_W-1:0] INT_ACC_MAX = 15'd32767;

    typedef enum logic [2:0] {
        FID_BALL_ANGLE  = 3'd0,
        FID_BALL_DIST   = 3'd1,
        FID_GOAL_BLUE   = 3'd2,
        FID_GOAL_YELLOW = 3'd3,
        FID_DERIV       = 3'd4,
        FID_POSE_X      = 3'd5,
        FID_POSE_Y      = 3'd6
    } t_field_id;

    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Number captured when a tag letter closes a field
    typedef struct packed {
        t_field_id              id;
        logic                   have_ball;
        logic                   negative;
        logic [1:0]             digits;
        logic [INT_W-1:0]       int_part;
    } t_tag_info;

endpackage

`default_nettype wire

// ===== src/tdfp_char_parser.sv =====
// ----------------------------------------------------------------------------
// tdfp_char_parser
// Per-character number build and tag capture into the first pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tdfp_char_parser #(
    parameter int FRAC_BITS   = 8,
    parameter int FRAC_DIGITS = 3
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [7:0]                             i_rx_byte,
    input  wire logic                                   i_have_ball,
    output logic                                        o_tag_valid,
    input  wire logic                                   i_tag_ready,
    output tdfp_pkg::t_tag_info                         o_tag,
    output logic [FRAC_BITS+tdfp_pkg::FRAC_ACC_W:0]     o_num
);
    import tdfp_pkg::*;

    localparam int NUM_W = FRAC_BITS + FRAC_ACC_W + 1;
    localparam logic [1:0] FRAC_CNT_MAX = 2'(FRAC_DIGITS);

    logic [INT_W-1:0]      r_int_acc, n_int_acc;
    logic [FRAC_ACC_W-1:0] r_frac_acc, n_frac_acc;
    logic [1:0]            r_frac_cnt, n_frac_cnt;
    logic                  r_negative, n_negative;
    logic                  r_seen_point, n_seen_point;
    logic                  r_stopped, n_stopped;
    logic                  r_any_seen, n_any_seen;

    logic                  r_tag_valid;
    t_tag_info             r_tag;
    logic [NUM_W-1:0]      r_num;

    logic                  accept;
    logic                  tag_hit;
    t_field_id             tag_id;
    logic                  is_eol;
    logic                  is_blank;
    logic                  is_sign;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [INT_W+3:0]      int_x10;
    logic [FRAC_ACC_W-1:0] frac_x10;
    logic [NUM_W-1:0]      half;
    logic [NUM_W-1:0]      n_num;

    assign o_ready     = !r_tag_valid || i_tag_ready;
    assign accept      = i_valid && o_ready;
    assign o_tag_valid = r_tag_valid;
    assign o_tag       = r_tag;
    assign o_num       = r_num;

    always_comb begin
        tag_hit = 1'b1;
        tag_id  = FID_BALL_ANGLE;
        unique case (i_rx_byte)
            CH_B:    tag_id = FID_BALL_ANGLE;
            CH_A:    tag_id = FID_BALL_DIST;
            CH_C:    tag_id = FID_GOAL_BLUE;
            CH_D:    tag_id = FID_GOAL_YELLOW;
            CH_F:    tag_id = FID_DERIV;
            CH_X:    tag_id = FID_POSE_X;
            CH_Y:    tag_id = FID_POSE_Y;
            default: tag_hit = 1'b0;
        endcase
    end

    always_comb begin
        case (i_rx_byte) inside
            CH_LF, CH_CR: is_eol = 1'b1;
            default:      is_eol = 1'b0;
        endcase
        case (i_rx_byte) inside
            CH_SP, CH_HT, CH_VT, CH_FF: is_blank = 1'b1;
            default:                    is_blank = 1'b0;
        endcase
        case (i_rx_byte) inside
            CH_PLUS, CH_MINUS: is_sign = 1'b1;
            default:           is_sign = 1'b0;
        endcase
    end

    assign is_digit = (i_rx_byte >= CH_0) && (i_rx_byte <= CH_9);
    assign digit    = i_rx_byte[3:0];
    assign int_x10  = ({4'd0, r_int_acc} << 3) + ({4'd0, r_int_acc} << 1)
                      + {{INT_W{1'b0}}, digit};
    assign frac_x10 = (r_frac_acc << 3) + (r_frac_acc << 1)
                      + {{(FRAC_ACC_W-4){1'b0}}, digit};

    // rounding offset: half of 10^digits
    always_comb begin
        case (r_frac_cnt)
            2'd1:    half = NUM_W'(5);
            2'd2:    half = NUM_W'(50);
            2'd3:    half = NUM_W'(500);
            default: half = '0;
        endcase
    end

    assign n_num = {1'b0, r_frac_acc, {FRAC_BITS{1'b0}}} + half;

    always_comb begin
        n_int_acc    = r_int_acc;
        n_frac_acc   = r_frac_acc;
        n_frac_cnt   = r_frac_cnt;
        n_negative   = r_negative;
        n_seen_point = r_seen_point;
        n_stopped    = r_stopped;
        n_any_seen   = r_any_seen;
        if (accept) begin
            if (tag_hit || is_eol) begin
                n_int_acc    = '0;
                n_frac_acc   = '0;
                n_frac_cnt   = '0;
                n_negative   = 1'b0;
                n_seen_point = 1'b0;
                n_stopped    = 1'b0;
                n_any_seen   = 1'b0;
            end else if (!r_stopped) begin
                if (!r_any_seen && is_blank) begin
                    n_any_seen = 1'b0;
                end else if (!r_any_seen && is_sign) begin
                    n_any_seen = 1'b1;
                    n_negative = (i_rx_byte == CH_MINUS);
                end else if (is_digit) begin
                    n_any_seen = 1'b1;
                    if (r_seen_point) begin
                        if (r_frac_cnt < FRAC_CNT_MAX) begin
                            n_frac_acc = frac_x10;
                            n_frac_cnt = r_frac_cnt + 2'd1;
                        end
                    end else if (int_x10 > {4'd0, INT_ACC_MAX}) begin
                        n_int_acc = INT_ACC_MAX;
                    end else begin
                        n_int_acc = int_x10[INT_W-1:0];
                    end
                end else if ((i_rx_byte == CH_POINT) && !r_seen_point) begin
                    n_any_seen   = 1'b1;
                    n_seen_point = 1'b1;
                end else begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_acc    <= '0;
            r_frac_acc   <= '0;
            r_frac_cnt   <= '0;
            r_negative   <= 1'b0;
            r_seen_point <= 1'b0;
            r_stopped    <= 1'b0;
            r_any_seen   <= 1'b0;
            r_tag_valid  <= 1'b0;
        end else begin
            r_int_acc    <= n_int_acc;
            r_frac_acc   <= n_frac_acc;
            r_frac_cnt   <= n_frac_cnt;
            r_negative   <= n_negative;
            r_seen_point <= n_seen_point;
            r_stopped    <= n_stopped;
            r_any_seen   <= n_any_seen;
            if (accept && tag_hit) begin
                r_tag_valid <= 1'b1;
            end else if (i_tag_ready) begin
                r_tag_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && tag_hit) begin
            r_tag.id        <= tag_id;
            r_tag.have_ball <= i_have_ball;
            r_tag.negative  <= r_negative;
            r_tag.digits    <= r_frac_cnt;
            r_tag.int_part  <= r_int_acc;
            r_num           <= n_num;
        end
    end

    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (tag_hit || is_eol)) |=>
        (r_int_acc == '0 && r_frac_cnt == '0 && !r_any_seen && !r_stopped))
        else $error("number not cleared after field end");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && !(accept && (tag_hit || is_eol))) |=> r_stopped)
        else $error("stopped number resumed");

    a_frac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_cnt <= FRAC_CNT_MAX)
        else $error("fraction digit count beyond limit");

endmodule

`default_nettype wire

// ===== src/tdfp_value_unit.sv =====
// ----------------------------------------------------------------------------
// tdfp_value_unit
// Fraction scaling by reciprocal multiply, magnitude, sign, wrap, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tdfp_value_unit #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire tdfp_pkg::t_tag_info                    i_tag,
    input  wire logic [FRAC_BITS+tdfp_pkg::FRAC_ACC_W:0] i_num,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output tdfp_pkg::t_field_id                         o_field_id,
    output logic signed [tdfp_pkg::VALUE_W-1:0]         o_value
);
    import tdfp_pkg::*;

    localparam int NUM_W  = FRAC_BITS + FRAC_ACC_W + 1;
    localparam int PROD_W = 2 * NUM_W + 1;
    localparam int QW     = FRAC_BITS + 1;
    localparam int MAG_W  = INT_W + FRAC_BITS + 1;
    localparam int EXT_W  = ((MAG_W > VALUE_W) ? MAG_W : VALUE_W) + 2;
    localparam int S10    = NUM_W + 4;
    localparam int S100   = NUM_W + 7;
    localparam int S1000  = NUM_W + 10;

    localparam logic [NUM_W:0] M10   = (NUM_W+1)'(((64'd1 << S10) + 64'd9) / 64'd10);
    localparam logic [NUM_W:0] M100  = (NUM_W+1)'(((64'd1 << S100) + 64'd99) / 64'd100);
    localparam logic [NUM_W:0] M1000 =
        (NUM_W+1)'(((64'd1 << S1000) + 64'd999) / 64'd1000);

    localparam logic signed [EXT_W-1:0] FIX_12  = EXT_W'(12 * (2 ** FRAC_BITS));
    localparam logic signed [EXT_W-1:0] FIX_180 = EXT_W'(180 * (2 ** FRAC_BITS));
    localparam logic signed [EXT_W-1:0] FIX_360 = EXT_W'(360 * (2 ** FRAC_BITS));
    localparam logic signed [EXT_W-1:0] VAL_MAX = EXT_W'(8388607);
    localparam logic signed [EXT_W-1:0] VAL_MIN = EXT_W'(-8388608);

    logic                         r_s2_valid;
    t_tag_info                    r_s2_tag;
    logic [PROD_W-1:0]            r_s2_prod;
    logic                         r_s3_valid;
    t_tag_info                    r_s3_tag;
    logic [MAG_W-1:0]             r_s3_mag;
    logic                         r_s4_valid;
    t_field_id                    r_s4_id;
    logic signed [VALUE_W-1:0]    r_s4_value;

    logic                         adv2, adv3, adv4;
    logic [NUM_W:0]               m_sel;
    logic [QW-1:0]                quot;
    logic [MAG_W-1:0]             n_mag;
    logic signed [EXT_W-1:0]      mag_ext, neg_val, wrap_val, pre_sat;
    logic signed [VALUE_W-1:0]    n_value;
    logic                         is_goal;

    assign adv4    = !r_s4_valid || i_ready;
    assign adv3    = !r_s3_valid || adv4;
    assign adv2    = !r_s2_valid || adv3;
    assign o_ready = adv2;
    assign o_valid = r_s4_valid;
    assign o_field_id = r_s4_id;
    assign o_value    = r_s4_value;

    always_comb begin
        case (i_tag.digits)
            2'd1:    m_sel = M10;
            2'd2:    m_sel = M100;
            2'd3:    m_sel = M1000;
            default: m_sel = '0;
        endcase
    end

    always_comb begin
        case (r_s2_tag.digits)
            2'd1:    quot = r_s2_prod[S10 +: QW];
            2'd2:    quot = r_s2_prod[S100 +: QW];
            2'd3:    quot = r_s2_prod[S1000 +: QW];
            default: quot = '0;
        endcase
    end

    assign n_mag = {1'b0, r_s2_tag.int_part, {FRAC_BITS{1'b0}}} + MAG_W'(quot);

    assign mag_ext  = signed'(EXT_W'(r_s3_mag));
    assign neg_val  = -mag_ext;
    assign wrap_val = mag_ext - FIX_360;
    assign is_goal  = (r_s3_tag.id == FID_GOAL_BLUE) || (r_s3_tag.id == FID_GOAL_YELLOW);

    always_comb begin
        if (r_s3_tag.have_ball && (r_s3_tag.id == FID_BALL_DIST)) begin
            pre_sat = FIX_12;
        end else if (r_s3_tag.negative) begin
            pre_sat = neg_val;
        end else if (is_goal && (mag_ext > FIX_180)) begin
            pre_sat = wrap_val;
        end else begin
            pre_sat = mag_ext;
        end
        if (pre_sat > VAL_MAX) begin
            n_value = VAL_MAX[VALUE_W-1:0];
        end else if (pre_sat < VAL_MIN) begin
            n_value = VAL_MIN[VALUE_W-1:0];
        end else begin
            n_value = pre_sat[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (adv2) begin
                r_s2_valid <= i_valid;
            end
            if (adv3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (adv4) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_tag  <= i_tag;
            r_s2_prod <= {{(NUM_W+1){1'b0}}, i_num} * {{NUM_W{1'b0}}, m_sel};
        end
        if (adv3) begin
            r_s3_tag <= r_s2_tag;
            r_s3_mag <= n_mag;
        end
        if (adv4) begin
            r_s4_id    <= r_s3_tag.id;
            r_s4_value <= n_value;
        end
    end

endmodule

`default_nettype wire

// ===== src/tdfp_pose_stage.sv =====
// ----------------------------------------------------------------------------
// tdfp_pose_stage
// Pose x memory, pose scaling by ten and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdfp_pose_stage #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire tdfp_pkg::t_field_id                    i_field_id,
    input  wire logic signed [tdfp_pkg::VALUE_W-1:0]    i_value,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [2:0]                                  o_field_id,
    output logic signed [tdfp_pkg::VALUE_W-1:0]         o_field_value,
    output logic                                        o_pose_update,
    output logic signed [tdfp_pkg::POSE_W-1:0]          o_pose_x_scaled,
    output logic signed [tdfp_pkg::POSE_W-1:0]          o_pose_y_scaled
);
    import tdfp_pkg::*;

    localparam logic signed [VALUE_W-1:0] POSE_NONE = VALUE_W'(-5 * (2 ** FRAC_BITS));

    logic                       r_valid;
    t_field_id                  r_field_id;
    logic signed [VALUE_W-1:0]  r_value;
    logic                       r_update;
    logic signed [POSE_W-1:0]   r_px;
    logic signed [POSE_W-1:0]   r_py;
    logic signed [VALUE_W-1:0]  r_last_pose_x;

    logic                       load;
    logic                       upd;
    logic signed [POSE_W-1:0]   v_wide, last_wide, v_x10, last_x10;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    assign v_wide    = POSE_W'(i_value);
    assign last_wide = POSE_W'(r_last_pose_x);
    assign v_x10     = (v_wide <<< 3) + (v_wide <<< 1);
    assign last_x10  = (last_wide <<< 3) + (last_wide <<< 1);
    assign upd       = (i_field_id == FID_POSE_Y) && (r_last_pose_x != POSE_NONE)
                       && (i_value != POSE_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_last_pose_x <= POSE_NONE;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load && (i_field_id == FID_POSE_X)) begin
                r_last_pose_x <= i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_field_id <= i_field_id;
            r_value    <= i_value;
            r_update   <= upd;
            r_px       <= upd ? last_x10 : '0;
            r_py       <= upd ? v_x10 : '0;
        end
    end

    assign o_valid         = r_valid;
    assign o_field_id      = r_field_id;
    assign o_field_value   = r_value;
    assign o_pose_update   = r_update;
    assign o_pose_x_scaled = r_px;
    assign o_pose_y_scaled = r_py;

    a_update_on_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_update) |-> (r_field_id == FID_POSE_Y))
        else $error("pose update on a field other than pose y");

    a_pose_x_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (i_field_id == FID_POSE_X)) |=> (r_last_pose_x == $past(i_value)))
        else $error("pose x not retained");

    a_scaled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_update) |-> (r_px == '0 && r_py == '0))
        else $error("scaled pose set without update");

endmodule

`default_nettype wire

// ===== src/tagged_decimal_field_parser_core.sv =====
// ----------------------------------------------------------------------------
// tagged_decimal_field_parser_core
// Serial decimal field parser with tag letters, pose scaling and saturation.
//
// Input channel: one ASCII character per beat (i_rx_byte) with i_have_ball,
// on i_valid / o_ready. Output channel: one result beat per tag letter
// (b a c d f x y) on o_valid / i_ready; all other characters only update the
// number being built and produce no beat.
// Throughput: one input beat per cycle, including tag letters, while o_ready is high.
// A tag result passes through the registered stages capture, fraction
// multiply, magnitude, sign/wrap/saturate and pose/result, in that order.
// The fraction multiply is the widest step: (FRAC_BITS+11) x (FRAC_BITS+12).
// Reset clears the number, empties the pipeline and sets the held pose x to
// the -5 sentinel. When the receiver stalls, results stay in the pipeline,
// bubbles close up, and o_ready drops once five results are held, whatever
// the next beat is; non-tag beats also wait while o_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_decimal_field_parser_core #(
    parameter int FRAC_BITS   = 8,
    parameter int FRAC_DIGITS = 3
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [7:0]                             i_rx_byte,
    input  wire logic                                   i_have_ball,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [2:0]                                  o_field_id,
    output logic signed [tdfp_pkg::VALUE_W-1:0]         o_field_value,
    output logic                                        o_pose_update,
    output logic signed [tdfp_pkg::POSE_W-1:0]          o_pose_x_scaled,
    output logic signed [tdfp_pkg::POSE_W-1:0]          o_pose_y_scaled
);
    import tdfp_pkg::*;

    localparam int NUM_W = FRAC_BITS + FRAC_ACC_W + 1;

    logic                      tag_valid, tag_ready;
    t_tag_info                 tag;
    logic [NUM_W-1:0]          num;
    logic                      val_valid, val_ready;
    t_field_id                 val_id;
    logic signed [VALUE_W-1:0] val_value;

    tdfp_char_parser #(
        .FRAC_BITS   (FRAC_BITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .i_have_ball (i_have_ball),
        .o_tag_valid (tag_valid),
        .i_tag_ready (tag_ready),
        .o_tag       (tag),
        .o_num       (num)
    );

    tdfp_value_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_value (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (tag_valid),
        .o_ready    (tag_ready),
        .i_tag      (tag),
        .i_num      (num),
        .o_valid    (val_valid),
        .i_ready    (val_ready),
        .o_field_id (val_id),
        .o_value    (val_value)
    );

    tdfp_pose_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pose (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (val_valid),
        .o_ready         (val_ready),
        .i_field_id      (val_id),
        .i_value         (val_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_field_id      (o_field_id),
        .o_field_value   (o_field_value),
        .o_pose_update   (o_pose_update),
        .o_pose_x_scaled (o_pose_x_scaled),
        .o_pose_y_scaled (o_pose_y_scaled)
    );

endmodule

`default_nettype wire
